// ----- design/input_event_sequence_matcher_unit_assert.svh -----
// Assertion macros used by the checker file of the event sequence matcher.
`ifndef INPUT_EVENT_SEQUENCE_MATCHER_UNIT_ASSERT_SVH
`define INPUT_EVENT_SEQUENCE_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define IESM_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("iesm assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define IESM_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("iesm assertion failed");

// Next-cycle implication that is also checked across reset.
`define IESM_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("iesm assertion failed");

`endif

// ----- design/iesm_pkg.sv -----
package iesm_pkg;

  localparam int PATTERN_SLOTS_DEF  = 6;
  localparam int PATTERN_LENGTH_DEF = 8;
  localparam int MAX_SLOTS          = 6;
  localparam int MAX_LENGTH         = 8;

  localparam int CODE_W  = 5;
  localparam int MASK_W  = 6;
  localparam int PROG_W  = 3;
  localparam int LEN_W   = 4;
  localparam int CFG_W   = 41;
  localparam int IDX_W   = 3;
  localparam int EXCL_BIT = 40;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [7:0] KIND_BUTTON = 8'h01;
  localparam logic [7:0] KIND_AXIS   = 8'h02;
  localparam logic [7:0] AXIS_HORIZ  = 8'h00;
  localparam logic [7:0] AXIS_VERT   = 8'h01;
  localparam logic [7:0] BTN_LAST    = 8'h05;
  localparam logic [7:0] TURBO_ID    = 8'h0b;

  localparam logic [IDX_W-1:0] REG_PATTERNS_IN_USE = 3'd6;

  localparam logic [CODE_W-1:0] CODE_NONE     = 5'd0;
  localparam logic [CODE_W-1:0] CODE_RIGHT    = 5'd1;
  localparam logic [CODE_W-1:0] CODE_LEFT     = 5'd2;
  localparam logic [CODE_W-1:0] CODE_H_NEUT   = 5'd3;
  localparam logic [CODE_W-1:0] CODE_DOWN     = 5'd4;
  localparam logic [CODE_W-1:0] CODE_UP       = 5'd5;
  localparam logic [CODE_W-1:0] CODE_V_NEUT   = 5'd6;
  localparam logic [CODE_W-1:0] CODE_BTN_BASE = 5'd7;
  localparam logic [CODE_W-1:0] CODE_TURBO_PR = 5'd19;
  localparam logic [CODE_W-1:0] CODE_TURBO_RL = 5'd20;
  localparam logic [CODE_W-1:0] CODE_MAX      = 5'd20;

  typedef logic [CFG_W-1:0]  pattern_t;
  typedef logic [PROG_W-1:0] prog_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Number of codes before the first zero code, capped at plen.
  function automatic len_t pattern_len(input pattern_t pat, input int plen);
    len_t len;
    logic found;
    len   = len_t'(plen);
    found = 1'b0;
    for (int k = 0; k < MAX_LENGTH; k++) begin
      if (!found && (k < plen) && (pat[k*CODE_W +: CODE_W] == CODE_NONE)) begin
        len   = len_t'(k);
        found = 1'b1;
      end
    end
    return len;
  endfunction

endpackage

// ----- design/iesm_event_map.sv -----
module iesm_event_map (
  input  logic [7:0]                  event_kind,
  input  logic [7:0]                  event_source,
  input  logic signed [15:0]          event_level,
  output logic [iesm_pkg::CODE_W-1:0] event_code
);
  import iesm_pkg::*;

  logic active;
  logic neg;

  assign active = (event_level != 16'sd0);
  assign neg    = event_level[15];

  always_comb begin
    event_code = CODE_NONE;
    if (event_kind == KIND_AXIS) begin
      if (event_source == AXIS_HORIZ) begin
        event_code = !active ? CODE_H_NEUT : (neg ? CODE_LEFT : CODE_RIGHT);
      end else if (event_source == AXIS_VERT) begin
        event_code = !active ? CODE_V_NEUT : (neg ? CODE_UP : CODE_DOWN);
      end
    end else if (event_kind == KIND_BUTTON) begin
      if (event_source <= BTN_LAST) begin
        event_code = CODE_BTN_BASE + {1'b0, event_source[2:0], 1'b0}
                     + {{(CODE_W-1){1'b0}}, ~active};
      end else if (event_source == TURBO_ID) begin
        // The turbo button reports the opposite level.
        event_code = active ? CODE_TURBO_RL : CODE_TURBO_PR;
      end
    end
  end

endmodule

// ----- design/input_event_sequence_matcher_unit.sv -----
// Joystick command-sequence matcher. Each input transaction carries one raw
// event (kind in tuser, source and signed level in tdata); the block maps it
// to an event code and steps up to PATTERN_SLOTS command patterns, returning
// one result transaction per event with the code, the mask of completed
// patterns and the exclusive flag. One event is taken every clock cycle while
// the output accepts results; the input register takes the event, and the
// result register then captures the outcome of a single matching stage that
// also updates the per-pattern progress registers. While a result waits, the
// input register holds one more event and then the input stalls. The user
// must write pattern and slot-count registers only while no event is in
// flight; the block itself does not enforce this.
module input_event_sequence_matcher_unit #(
  parameter int PATTERN_SLOTS  = iesm_pkg::PATTERN_SLOTS_DEF,
  parameter int PATTERN_LENGTH = iesm_pkg::PATTERN_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] event_source, [23:8] event_level
  input  logic [iesm_pkg::IN_DATA_W-1:0]    in_tdata,
  // [7:0] event_kind
  input  logic [iesm_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [4:0] event_code, [10:5] fired_mask, [11] exclusive_fired, [15:12] zero
  output logic [iesm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [iesm_pkg::IDX_W-1:0]        cfg_index,
  input  logic [iesm_pkg::CFG_W-1:0]        cfg_wdata
);
  import iesm_pkg::*;

  pattern_t             slot_r [PATTERN_SLOTS];
  logic [IDX_W-1:0]     in_use_r;
  prog_t                prog_r [PATTERN_SLOTS];
  prog_t                prog_nxt [PATTERN_SLOTS];

  logic                 in_valid_r;
  logic [7:0]           kind_r;
  logic [7:0]           source_r;
  logic signed [15:0]   level_r;

  logic                 out_valid_r;
  logic [CODE_W-1:0]    code_r;
  logic [MASK_W-1:0]    mask_r;
  logic                 excl_r;

  logic                 in_acc;
  logic                 advance;
  logic [CODE_W-1:0]    code;
  logic [IDX_W-1:0]     n_eff;

  logic [PATTERN_SLOTS-1:0] in_use;
  logic [PATTERN_SLOTS-1:0] hit;
  logic [PATTERN_SLOTS-1:0] done;
  logic [PATTERN_SLOTS-1:0] excl_hit;
  logic [PATTERN_SLOTS-1:0] fired;
  logic                     any_excl;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  iesm_event_map u_map (
    .event_kind   (kind_r),
    .event_source (source_r),
    .event_level  (level_r),
    .event_code   (code)
  );

  assign n_eff = (in_use_r > IDX_W'(PATTERN_SLOTS)) ? IDX_W'(PATTERN_SLOTS) : in_use_r;

  always_comb begin
    len_t         len;
    logic [LEN_W-1:0] p_ext;
    for (int i = 0; i < PATTERN_SLOTS; i++) begin
      len         = pattern_len(slot_r[i], PATTERN_LENGTH);
      p_ext       = {1'b0, prog_r[i]};
      in_use[i]   = IDX_W'(i) < n_eff;
      hit[i]      = in_use[i] && (len != '0) && (p_ext < len)
                    && (slot_r[i][prog_r[i]*CODE_W +: CODE_W] == code);
      done[i]     = hit[i] && ((p_ext + LEN_W'(1)) >= len);
      excl_hit[i] = done[i] && slot_r[i][EXCL_BIT];
    end
  end

  always_comb begin
    logic blocked;
    blocked = 1'b0;
    for (int i = 0; i < PATTERN_SLOTS; i++) begin
      fired[i] = done[i] && !blocked;
      blocked  = blocked || excl_hit[i];
    end
    any_excl = |excl_hit;
  end

  always_comb begin
    for (int i = 0; i < PATTERN_SLOTS; i++) begin
      prog_nxt[i] = prog_r[i];
      if (advance) begin
        if (any_excl) begin
          prog_nxt[i] = '0;
        end else if (in_use[i]) begin
          prog_nxt[i] = (hit[i] && !done[i]) ? prog_r[i] + PROG_W'(1) : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
        slot_r[i] <= '0;
        prog_r[i] <= '0;
      end
      in_use_r    <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
        prog_r[i] <= prog_nxt[i];
        if (cfg_we && (cfg_index == IDX_W'(i))) begin
          slot_r[i] <= cfg_wdata;
        end
      end
      if (cfg_we && (cfg_index == REG_PATTERNS_IN_USE)) begin
        in_use_r <= cfg_wdata[IDX_W-1:0];
      end
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= in_tuser[7:0];
      source_r <= in_tdata[7:0];
      level_r  <= in_tdata[23:8];
    end
    if (advance) begin
      code_r <= code;
      mask_r <= MASK_W'(fired);
      excl_r <= any_excl;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-CODE_W-MASK_W-1){1'b0}}, excl_r, mask_r, code_r};

endmodule

// ----- design/iesm_checker.sv -----
`include "input_event_sequence_matcher_unit_assert.svh"

module iesm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [iesm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import iesm_pkg::*;

  // A result that was not taken stays on the bus unchanged.
  `IESM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // An exclusive completion always reports the pattern that fired it.
  `IESM_ASSERT_IMP(a_excl_mask, out_tvalid && out_tdata[11], out_tdata[10:5] != '0)
  // Event codes never leave the defined range.
  `IESM_ASSERT_IMP(a_code_range, out_tvalid, out_tdata[4:0] <= CODE_MAX)
  // No result and no input back-pressure right after reset.
  `IESM_ASSERT_RST(a_reset_idle, !rst_n, !out_tvalid && in_tready)
  // The input only stalls while a result is waiting to be taken.
  `IESM_ASSERT_IMP(a_ready_stall, !in_tready, out_tvalid && !out_tready)

endmodule

bind input_event_sequence_matcher_unit iesm_checker u_iesm_checker (.*);

// ----- tb/tb_input_event_sequence_matcher_unit.sv -----
module tb_input_event_sequence_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import iesm_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASES = 15;
  localparam int EVENTS_PER_PHASE = 100;
  localparam int PLAN_ROWS = 30;
  localparam logic [IDX_W-1:0] REG_PATTERN_0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam pattern_t NO_VALUE = '0;

  typedef struct packed {
    logic [7:0]  kind;
    logic [7:0]  src;
    logic [15:0] lvl;
  } raw_event_t;

  typedef struct packed {
    logic [3:0]        pad;
    logic              excl;
    logic [MASK_W-1:0] fired;
    logic [CODE_W-1:0] code;
  } match_result_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_op_e;

  typedef struct packed {
    row_op_e           op;
    logic [IDX_W-1:0]  idx;
    pattern_t          value;
    logic [7:0]        kind;
    logic [7:0]        src;
    logic [15:0]       lvl;
    logic              typed;
    logic [CODE_W-1:0] code;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // [7:0] event_source, [23:8] event_level
  logic [IN_DATA_W-1:0]  in_tdata;
  // [7:0] event_kind
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // [4:0] event_code, [10:5] fired_mask, [11] exclusive_fired, [15:12] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  pattern_t         slot_pattern [MAX_SLOTS];
  logic [PROG_W-1:0] slot_progress [MAX_SLOTS];
  logic [IDX_W-1:0] slots_in_use;

  match_result_t expected_results [$];
  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_HORIZ, 16'h7fff, 1'b1, CODE_RIGHT},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_HORIZ, 16'h8000, 1'b1, CODE_LEFT},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_HORIZ, 16'h0000, 1'b1, CODE_H_NEUT},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_VERT, 16'h0001, 1'b1, CODE_DOWN},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_VERT, 16'hffff, 1'b1, CODE_UP},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_VERT, 16'h0000, 1'b1, CODE_V_NEUT},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, 8'hff, 16'h1234, 1'b1, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, 8'h00, 16'h0001, 1'b1, CODE_BTN_BASE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, BTN_LAST, 16'h0000, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h0000, 1'b1, CODE_TURBO_PR},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h8000, 1'b1, CODE_TURBO_RL},
    '{ROW_WRITE, REG_PATTERN_0, pattern_t'({CODE_LEFT, CODE_RIGHT}),
      8'h00, 8'h00, 16'h0000, 1'b0, CODE_NONE},
    '{ROW_WRITE, REG_PATTERN_0 + 3'd1, {1'b1, 35'd0, CODE_BTN_BASE},
      8'h00, 8'h00, 16'h0000, 1'b0, CODE_NONE},
    '{ROW_WRITE, REG_PATTERN_0 + 3'd2, pattern_t'({8{CODE_TURBO_RL}}),
      8'h00, 8'h00, 16'h0000, 1'b0, CODE_NONE},
    '{ROW_WRITE, REG_UNUSED, {CFG_W{1'b1}}, 8'h00, 8'h00, 16'h0000, 1'b0, CODE_NONE},
    '{ROW_WRITE, REG_PATTERNS_IN_USE, pattern_t'(7), 8'h00, 8'h00, 16'h0000, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_HORIZ, 16'h0100, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_HORIZ, 16'hc000, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_HORIZ, 16'h0100, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, 8'hff, 8'h00, 16'hffff, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_AXIS, AXIS_HORIZ, 16'hc000, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h0001, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h0001, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h0001, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h0001, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h0001, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h0001, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'h0001, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, TURBO_ID, 16'hffff, 1'b0, CODE_NONE},
    '{ROW_EVENT, REG_PATTERN_0, NO_VALUE, KIND_BUTTON, 8'h00, 16'h7fff, 1'b0, CODE_NONE}
  };

  input_event_sequence_matcher_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int code_count(pattern_t pat);
    int len;
    len = 0;
    while (len < MAX_LENGTH && pat[len*CODE_W +: CODE_W] != CODE_NONE) len++;
    return len;
  endfunction

  function automatic match_result_t match_event(raw_event_t ev);
    match_result_t r;
    logic active;
    int n;
    int len;
    r = '0;
    active = (ev.lvl != 16'h0000);
    if (ev.kind == KIND_AXIS) begin
      if (ev.src == AXIS_HORIZ) begin
        r.code = !active ? CODE_H_NEUT : (ev.lvl[15] ? CODE_LEFT : CODE_RIGHT);
      end else if (ev.src == AXIS_VERT) begin
        r.code = !active ? CODE_V_NEUT : (ev.lvl[15] ? CODE_UP : CODE_DOWN);
      end
    end else if (ev.kind == KIND_BUTTON) begin
      if (ev.src <= BTN_LAST) begin
        r.code = CODE_W'(int'(CODE_BTN_BASE) + 2 * int'(ev.src) + (active ? 0 : 1));
      end else if (ev.src == TURBO_ID) begin
        r.code = active ? CODE_TURBO_RL : CODE_TURBO_PR;
      end
    end
    n = (slots_in_use > MAX_SLOTS) ? MAX_SLOTS : int'(slots_in_use);
    for (int i = 0; i < n && !r.excl; i++) begin
      len = code_count(slot_pattern[i]);
      if (len == 0 || slot_progress[i] >= len ||
          slot_pattern[i][slot_progress[i]*CODE_W +: CODE_W] != r.code) begin
        slot_progress[i] = '0;
      end else if (slot_progress[i] + 1 >= len) begin
        slot_progress[i] = '0;
        r.fired[i] = 1'b1;
        if (slot_pattern[i][EXCL_BIT]) begin
          r.excl = 1'b1;
          for (int j = 0; j < MAX_SLOTS; j++) slot_progress[j] = '0;
        end
      end else begin
        slot_progress[i] = slot_progress[i] + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] nonzero_level();
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic raw_event_t encode_code(logic [CODE_W-1:0] c);
    raw_event_t ev;
    int b;
    ev.kind = KIND_AXIS;
    ev.src = AXIS_HORIZ;
    ev.lvl = 16'h0000;
    case (c)
      CODE_RIGHT: ev.lvl = 16'($urandom_range(1, 32767));
      CODE_LEFT: ev.lvl = 16'h8000 | 16'($urandom_range(0, 32767));
      CODE_H_NEUT: ;
      CODE_DOWN: begin
        ev.src = AXIS_VERT;
        ev.lvl = 16'($urandom_range(1, 32767));
      end
      CODE_UP: begin
        ev.src = AXIS_VERT;
        ev.lvl = 16'h8000 | 16'($urandom_range(0, 32767));
      end
      CODE_V_NEUT: ev.src = AXIS_VERT;
      CODE_TURBO_PR: begin
        ev.kind = KIND_BUTTON;
        ev.src = TURBO_ID;
      end
      CODE_TURBO_RL: begin
        ev.kind = KIND_BUTTON;
        ev.src = TURBO_ID;
        ev.lvl = nonzero_level();
      end
      default: begin
        if (c >= CODE_BTN_BASE && c < CODE_TURBO_PR) begin
          b = int'(c) - int'(CODE_BTN_BASE);
          ev.kind = KIND_BUTTON;
          ev.src = 8'(b / 2);
          if (b % 2 == 0) ev.lvl = nonzero_level();
        end else begin
          ev.lvl = 16'($urandom);
          case ($urandom_range(0, 2))
            0: begin
              ev.kind = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(3, 255));
              ev.src = 8'($urandom);
            end
            1: ev.src = 8'($urandom_range(2, 255));
            default: begin
              ev.kind = KIND_BUTTON;
              ev.src = $urandom_range(0, 1) ? 8'($urandom_range(6, 10))
                                            : 8'($urandom_range(12, 255));
            end
          endcase
        end
      end
    endcase
    return ev;
  endfunction

  function automatic raw_event_t noise_event();
    raw_event_t ev;
    if ($urandom_range(0, 1)) return encode_code(CODE_W'($urandom_range(0, 20)));
    ev.kind = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    ev.src = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 15));
    ev.lvl = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    return ev;
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, pattern_t value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx < REG_PATTERNS_IN_USE) slot_pattern[idx] = value;
    else if (idx == REG_PATTERNS_IN_USE) slots_in_use = value[IDX_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_event(raw_event_t ev, logic typed, logic [CODE_W-1:0] code);
    match_result_t r;
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 25);
    end
    in_tvalid <= 1'b1;
    in_tuser <= ev.kind;
    in_tdata <= {ev.lvl, ev.src};
    do @(posedge clk); while (!in_tready);
    r = match_event(ev);
    if (typed) begin
      r = '0;
      r.code = code;
    end
    expected_results.push_back(r);
    items_sent++;
  endtask

  task automatic report_field(string field, int unsigned exp_v, int unsigned act_v);
    $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_monitor
    match_result_t got;
    match_result_t want;
    out_tready <= steady || ($urandom_range(0, 99) >= 25);
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.code !== want.code) report_field("event_code", want.code, got.code);
        if (got.fired !== want.fired) report_field("fired_mask", want.fired, got.fired);
        if (got.excl !== want.excl) report_field("exclusive_fired", want.excl, got.excl);
        if (got.pad !== want.pad) report_field("padding", want.pad, got.pad);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("input_event_sequence_matcher_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int s;
    int k;
    int n;
    int len;
    int target;
    pattern_t pat;
    logic [IDX_W-1:0] in_use;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    out_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_pattern[i] = '0;
      slot_progress[i] = '0;
    end
    slots_in_use = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (directed_plan[r].op == ROW_WRITE) begin
        write_reg(directed_plan[r].idx, directed_plan[r].value);
      end else begin
        send_event({directed_plan[r].kind, directed_plan[r].src, directed_plan[r].lvl},
                   directed_plan[r].typed, directed_plan[r].code);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 2);
      for (s = 0; s < MAX_SLOTS; s++) begin
        case ($urandom_range(0, 9))
          0: pat = '0;
          1: pat = '1;
          2: pat = pattern_t'({$urandom, $urandom});
          default: begin
            pat = pattern_t'({$urandom, $urandom});
            len = $urandom_range(1, MAX_LENGTH);
            for (k = 0; k < len; k++) begin
              pat[k*CODE_W +: CODE_W] = ($urandom_range(0, 19) == 0)
                  ? CODE_W'($urandom_range(21, 31))
                  : CODE_W'($urandom_range(1, $urandom_range(0, 1) ? 8 : 20));
            end
            if (len < MAX_LENGTH) pat[len*CODE_W +: CODE_W] = CODE_NONE;
            pat[EXCL_BIT] = ($urandom_range(0, 3) == 0);
          end
        endcase
        write_reg(REG_PATTERN_0 + IDX_W'(s), pat);
      end
      if (phase == 0) in_use = IDX_W'(MAX_SLOTS);
      else if (phase == 1) in_use = '1;
      else in_use = IDX_W'($urandom_range(0, 7));
      write_reg(REG_PATTERNS_IN_USE, pattern_t'(in_use));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, pattern_t'({$urandom, $urandom}));
      n = (in_use > MAX_SLOTS) ? MAX_SLOTS : int'(in_use);
      target = items_sent + EVENTS_PER_PHASE;
      while (items_sent < target) begin
        if (n > 0 && $urandom_range(0, 9) < 8) begin
          s = $urandom_range(0, n - 1);
          len = code_count(slot_pattern[s]);
          if (len == 0) send_event(noise_event(), 1'b0, CODE_NONE);
          for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 11) == 0) send_event(noise_event(), 1'b0, CODE_NONE);
            send_event(encode_code(slot_pattern[s][k*CODE_W +: CODE_W]), 1'b0, CODE_NONE);
          end
        end else begin
          send_event(noise_event(), 1'b0, CODE_NONE);
        end
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("input_event_sequence_matcher_unit: match");
    end else begin
      $display("input_event_sequence_matcher_unit: mismatch");
    end
    $finish;
  end

endmodule
